### sv/fowf_pkg.sv
package fowf_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned PosW  = 4;

  // one result, kept in the lowest bit
  typedef struct packed {
    logic            truncated;
    logic            table_full;
    logic [PosW-1:0] list_position;
    logic            kept;
  } result_t;

endpackage

### sv/fowf_front.sv
module fowf_front #(
  parameter int unsigned MAX_WORDS = 16,
  parameter int unsigned MAX_CHARS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [fowf_pkg::CharW-1:0]   char_code_i,
  input  logic                         word_end_i,
  input  logic                         new_list_i,
  output logic                         res_valid_o,
  output fowf_pkg::result_t            res_o
);

  localparam int unsigned CW  = $clog2(MAX_CHARS + 1);
  localparam int unsigned AW  = $clog2(MAX_CHARS);
  localparam int unsigned SWW = $clog2(MAX_WORDS + 1);
  localparam int unsigned WIW = $clog2(MAX_WORDS);

  logic [SWW-1:0]             sw_q, sw_d;
  logic [CW-1:0]              ci_q, ci_d;
  logic [MAX_WORDS-1:0]       sm_q, sm_d;
  logic                       ov_q, ov_d;
  logic [CW-1:0]              len_q [MAX_WORDS];
  logic [fowf_pkg::CharW-1:0] rd_q  [MAX_WORDS];

  logic [SWW-1:0]       sw_eff;
  logic [CW-1:0]        eff;
  logic                 in_range;
  logic [MAX_WORDS-1:0] sm_eff, sm_nxt;
  logic [CW-1:0]        wlen;
  logic                 found;
  logic [SWW-1:0]       pos;
  logic [SWW+3:0]       pos_ext;
  logic                 room;
  logic                 ov_fin;
  logic                 store_len;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [WIW-1:0]       len_addr;

  always_comb begin
    sw_eff   = new_list_i ? '0 : sw_q;
    eff      = new_list_i ? '0 : ci_q;
    sm_eff   = new_list_i ? '1 : sm_q;
    in_range = (eff < CW'(MAX_CHARS));
    room     = (sw_eff < SWW'(MAX_WORDS));
    for (int w = 0; w < MAX_WORDS; w++) begin
      sm_nxt[w] = sm_eff[w];
      if (in_range && (SWW'(w) < sw_eff)) begin
        sm_nxt[w] = sm_eff[w] && (len_q[w] > eff) && (rd_q[w] == char_code_i);
      end
    end
    wlen   = in_range ? eff + CW'(1) : eff;
    ov_fin = (ov_q && !new_list_i) || !in_range;
    found  = 1'b0;
    pos    = '0;
    for (int w = MAX_WORDS - 1; w >= 0; w--) begin
      if ((SWW'(w) < sw_eff) && sm_nxt[w] && (len_q[w] == wlen)) begin
        found = 1'b1;
        pos   = SWW'(w);
      end
    end
    store_len = 1'b0;
    if (!found) begin
      if (room) begin
        pos       = sw_eff;
        store_len = word_end_i;
      end else begin
        pos = '0;
      end
    end
    pos_ext = {4'b0, pos};

    // next state, held when no transaction
    sw_d = sw_q;
    ci_d = ci_q;
    sm_d = sm_q;
    ov_d = ov_q;
    if (accept_i) begin
      if (word_end_i) begin
        sw_d = store_len ? sw_eff + SWW'(1) : sw_eff;
        ci_d = '0;
        sm_d = '1;
        ov_d = 1'b0;
      end else begin
        sw_d = sw_eff;
        ci_d = wlen;
        sm_d = sm_nxt;
        ov_d = ov_fin;
      end
    end
    rd_addr  = ci_d[AW-1:0];
    wr_addr  = eff[AW-1:0];
    len_addr = sw_eff[WIW-1:0];
  end

  assign res_valid_o            = accept_i && word_end_i;
  assign res_o.kept             = !found;
  assign res_o.list_position    = pos_ext[3:0];
  assign res_o.table_full       = !found && !room;
  assign res_o.truncated        = ov_fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= '0;
      ci_q <= '0;
      sm_q <= '1;
      ov_q <= 1'b0;
    end else begin
      sw_q <= sw_d;
      ci_q <= ci_d;
      sm_q <= sm_d;
      ov_q <= ov_d;
    end
  end

  // a length is stored only while there is room, so the slot index is in range
  always_ff @(posedge clk_i) begin
    if (accept_i && store_len) begin
      len_q[len_addr] <= wlen;
    end
  end

  // one character memory per word slot, all read at the next index
  for (genvar g = 0; g < MAX_WORDS; g++) begin : g_slot
    logic [fowf_pkg::CharW-1:0] mem [MAX_CHARS];
    logic                       we;
    assign we = accept_i && in_range && (sw_eff == SWW'(g));
    always_ff @(posedge clk_i) begin
      if (we) begin
        mem[wr_addr] <= char_code_i;
      end
      // forward a write that lands on the address being fetched
      if (we && (wr_addr == rd_addr)) begin
        rd_q[g] <= char_code_i;
      end else begin
        rd_q[g] <= mem[rd_addr];
      end
    end
  end

endmodule

### sv/fowf_queue.sv
module fowf_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fowf_pkg::result_t push_data_i,
  output logic              space_o,
  output logic              valid_o,
  input  logic              ready_i,
  output fowf_pkg::result_t data_o
);

  fowf_pkg::result_t entry_q [2];
  logic              wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              pop;

  always_comb begin
    pop    = valid_o && ready_i;
    wptr_d = push_i ? !wptr_q : wptr_q;
    rptr_d = pop ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  assign space_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = entry_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

endmodule

### sv/first_occurrence_word_filter_unit.sv
// A word's result is classified in the cycle its last character is taken and pushed into the result queue for m_axis.
// Throughput: one character per cycle while the result queue has room.
// The rate is set by the per-slot character memories, all read at the next index in parallel.
// Reset clears the word count, character index, match flags, truncation flag and the result queue;
// stored characters and lengths hold no reset value and are read only after being written.
module first_occurrence_word_filter_unit #(
  parameter int unsigned MAX_WORDS = 16,
  parameter int unsigned MAX_CHARS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] char_code
  input  logic       s_axis_tlast_i,  // word_end
  input  logic       s_axis_tuser_i,  // new_list
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o   // [0] kept, [4:1] list_position, [5] table_full,
                                      // [6] truncated, [7] zero
);

  logic              space;
  logic              accept;
  logic              res_valid;
  fowf_pkg::result_t res;
  fowf_pkg::result_t head;

  // take a transaction whenever the result queue has room
  assign s_axis_tready_o = space;
  assign accept          = s_axis_tvalid_i && space;

  // front: match characters against every stored word, classify at word end
  fowf_front #(
    .MAX_WORDS (MAX_WORDS),
    .MAX_CHARS (MAX_CHARS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_code_i (s_axis_tdata_i),
    .word_end_i  (s_axis_tlast_i),
    .new_list_i  (s_axis_tuser_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // back: hold results until the sink takes them
  fowf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .data_o      (head)
  );

  assign m_axis_tdata_o = {1'b0, head};

endmodule

### bench/first_occurrence_word_filter_unit_checker.sv
module first_occurrence_word_filter_unit_checker #(
  parameter int unsigned MAX_WORDS = 16,
  parameter int unsigned MAX_CHARS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  input  logic       s_axis_tready_i,
  input  logic [7:0] s_axis_tdata_i,
  input  logic       s_axis_tlast_i,
  input  logic       s_axis_tuser_i,
  input  logic       m_axis_tvalid_i,
  input  logic       m_axis_tready_i,
  input  logic [7:0] m_axis_tdata_i,
  output int         errors_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the word table
  logic [fowf_pkg::CharW-1:0] words_q [MAX_WORDS][MAX_CHARS];
  int unsigned      lens_q [MAX_WORDS];
  int unsigned      count_q;
  int unsigned      idx_q;
  logic [MAX_WORDS-1:0] match_q;
  logic             long_q;
  fowf_pkg::result_t verdicts_q [$];

  assign pending_o = verdicts_q.size();

  initial errors_o = 0;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors_o++;
  endtask

  // advance the shadow table by one character; queue a verdict at word end
  task automatic take_char(input logic [7:0] c, input logic last, input logic fresh);
    fowf_pkg::result_t r;
    bit hit;
    if (fresh) begin
      count_q = 0; idx_q = 0; long_q = 0; match_q = '1;
    end
    if (idx_q < MAX_CHARS) begin
      for (int w = 0; w < MAX_WORDS; w++)
        if (w < count_q && !(lens_q[w] > idx_q && words_q[w][idx_q] == c)) match_q[w] = 0;
      if (count_q < MAX_WORDS) words_q[count_q][idx_q] = c;
      idx_q++;
    end else begin
      long_q = 1;
    end
    if (!last) return;
    r = '0;
    r.kept = 1;
    hit = 0;
    for (int w = 0; w < MAX_WORDS; w++)
      if (!hit && w < count_q && match_q[w] && lens_q[w] == idx_q) begin
        hit = 1;
        r.kept = 0;
        r.list_position = fowf_pkg::PosW'(w);
      end
    if (!hit) begin
      if (count_q < MAX_WORDS) begin
        lens_q[count_q] = idx_q;
        r.list_position = fowf_pkg::PosW'(count_q);
        count_q++;
      end else begin
        r.table_full = 1;
      end
    end
    r.truncated = long_q;
    verdicts_q.push_back(r);
    idx_q = 0; long_q = 0; match_q = '1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fowf_pkg::result_t got, want;
    if (!rst_ni) begin
      count_q = 0; idx_q = 0; long_q = 0; match_q = '1;
      verdicts_q.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[6:0];
        if (m_axis_tdata_i[7]) report("padding bit set");
        if (verdicts_q.size() == 0) begin
          report("result with no word pending");
        end else begin
          want = verdicts_q.pop_front();
          if (got.kept != want.kept) report($sformatf("kept %0b exp %0b", got.kept, want.kept));
          if (got.list_position != want.list_position)
            report($sformatf("position %0d exp %0d", got.list_position, want.list_position));
          if (got.table_full != want.table_full)
            report($sformatf("table_full %0b exp %0b", got.table_full, want.table_full));
          if (got.truncated != want.truncated)
            report($sformatf("truncated %0b exp %0b", got.truncated, want.truncated));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        take_char(s_axis_tdata_i, s_axis_tlast_i, s_axis_tuser_i);
    end
  end

endmodule

### bench/first_occurrence_word_filter_unit_tb.sv
module first_occurrence_word_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 20000;

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       s_tvalid = 0;
  logic       s_tready;
  logic [7:0] s_tdata = '0;
  logic       s_tlast = 0;
  logic       s_tuser = 0;
  logic       m_tvalid;
  logic       m_tready = 0;
  logic [7:0] m_tdata;
  int         errors;
  int         pending;

  // idle odds in percent, per side
  int unsigned send_idle = 6;
  int unsigned recv_idle = 67;
  bit          hold_off = 0;
  int unsigned stalls = 0;

  // small vocabulary so that repeats are common
  logic [7:0] vocab [8][$];

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  first_occurrence_word_filter_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  first_occurrence_word_filter_unit_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_off) begin
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_ni) begin
      stalls <= 0;
    end else begin
      stalls <= stalls + 1;
      if (stalls >= WatchdogLimit) begin
        $display("first_occurrence_word_filter_unit_tb NOT OK");
        $finish;
      end
    end
  end

  // offer one character, hold it until accepted
  task automatic send(input logic [7:0] c, input logic last, input logic fresh);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk_i);
    end
    s_tvalid <= 1;
    s_tdata  <= c;
    s_tlast  <= last;
    s_tuser  <= fresh;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic send_word(input logic [7:0] w[$], input logic fresh);
    for (int i = 0; i < w.size(); i++) send(w[i], i == w.size() - 1, fresh && i == 0);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic random_phase(input int n);
    logic [7:0] w[$];
    int k;
    int r;
    for (int i = 0; i < n; i += w.size()) begin
      r = $urandom_range(99);
      k = $urandom_range(7);
      if (r < 70) begin
        w = vocab[k];
      end else begin
        w.delete();
        // occasional overlong word, mostly short ones
        repeat (r < 75 ? $urandom_range(33, 40) : $urandom_range(1, 6))
          w.push_back($urandom_range(255));
        if (r < 78) vocab[k] = w;
      end
      send_word(w, $urandom_range(99) < 4);
    end
  endtask

  initial begin
    logic [7:0] w[$];
    for (int k = 0; k < 8; k++) begin
      w.delete();
      repeat ($urandom_range(1, 4)) w.push_back($urandom_range(255));
      vocab[k] = w;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, duplicates, prefixes, overlong, new list with end
    send(8'h00, 1, 0);
    send(8'hFF, 1, 0);
    send(8'h00, 1, 0);
    send_word('{8'hFF, 8'h00}, 0);
    send_word('{8'hFF, 8'h00, 8'h55}, 0);
    send_word('{8'hFF, 8'h00}, 0);
    send(8'hAA, 0, 0);
    send(8'h11, 1, 1);         // abandons partial word, new list
    send(8'h11, 1, 0);
    w.delete();
    repeat (34) w.push_back(8'h5A);
    send_word(w, 0);
    w.delete();
    repeat (33) w.push_back(8'h5A);
    send_word(w, 0);
    drain();
    // fill the table past 16 words, then repeat an early one
    for (int i = 0; i < 20; i++) send(8'(i + 1), 1, i == 0);
    send(8'h01, 1, 0);
    drain();

    // long receiver hold-off while the sender keeps offering
    hold_off = 1;
    fork
      begin
        random_phase(30);
        // stop offering once the last character is taken
        s_tvalid <= 0;
      end
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
    join
    drain();

    random_phase(100);
    drain();
    send_idle = 67;
    recv_idle = 6;
    random_phase(100);
    drain();
    send_idle = 0;
    recv_idle = 0;
    random_phase(100);
    drain();

    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("first_occurrence_word_filter_unit_tb OK");
    end else begin
      $display("first_occurrence_word_filter_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
